FILE: sv/rmv_pkg.sv
// Shared types and constants for the running mean / variance outlier unit.
`timescale 1ns / 1ps
package rmv_pkg;

  localparam int SUM_WIDTH_DEF   = 48;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int CNT_W      = 8;    // step counter of the shared unit
  localparam int WIDE_BITS  = 128;  // exact product range before saturation
  localparam int RATIO_FRAC = 4;
  localparam int GROUP_W    = 16;
  localparam int SPREAD_W   = 64;
  localparam int TOTAL_W    = 32;
  localparam int RATIO_W    = 8;
  localparam int MSPREAD_W  = 32;
  localparam int MCOUNT_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [RATIO_W-1:0]   RATIO_RST   = 8'd100;
  localparam logic [MSPREAD_W-1:0] MSPREAD_RST = 32'd65536;
  localparam logic [MCOUNT_W-1:0]  MCOUNT_RST  = 16'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RATIO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MSPREAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MCOUNT  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OUTLIER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd3;

  typedef enum logic {OP_MUL = 1'b0, OP_DIV = 1'b1} op_t;

  typedef struct packed {
    logic             start;
    op_t              op;
    logic [CNT_W-1:0] nbits;
  } alu_ctl_t;

endpackage

FILE: sv/running_mean_variance_outlier_unit.sv
// Top level: weighted running mean / spread with outlier rejection.
//
//  channel | dir | words                      | handshake
//  in_     | in  | tdata = sample_sum, count  | in_tvalid  / in_tready
//  out_    | out | tdata = status..updates    | out_tvalid / out_tready
//  cfg_    | in  | cfg_index, cfg_data        | cfg_valid  / cfg_ready (always 1)
//
// One accepted word runs a chain of multiplies and divides before in_tready rises
// again: every multiply and divide runs one bit per cycle on the single shared
// shift/add unit. Outlier and overflow words leave after the threshold product;
// a zero group size goes straight to the output state. Reset is synchronous,
// active low, and restores the statistics, the configuration and the control state.
// in_tready is high only in idle; a stalled result holds in the output register and
// the sequencer waits in its output state until it frees up.
`timescale 1ns / 1ps
module running_mean_variance_outlier_unit #(
  parameter int SUM_WIDTH   = rmv_pkg::SUM_WIDTH_DEF,
  parameter int FRAC_BITS   = rmv_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = rmv_pkg::COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // sample_sum [SUM_WIDTH-1:0], sample_count [15:0], zero pad to bytes
  input  logic [((SUM_WIDTH+rmv_pkg::GROUP_W+7)/8)*8-1:0] in_tdata,
  input  logic in_tvalid,
  output logic in_tready,
  // status [1:0], mean_value, spread_sum [63:0], sample_total [31:0],
  // update_total [31:0], zero pad to bytes
  output logic [((rmv_pkg::STATUS_W+SUM_WIDTH+rmv_pkg::SPREAD_W+2*rmv_pkg::TOTAL_W+7)/8)*8-1:0]
               out_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rmv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rmv_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rmv_pkg::*;

  localparam int SW    = SUM_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int CW    = COUNT_WIDTH;
  localparam int QW    = 2*SW + CW;
  localparam int UW    = QW + GROUP_W;
  localparam int NUM_W = ((CW > F) ? SW + CW : SW + F) + 1;
  localparam int CMP_W = UW + F;
  localparam int OUT_W = ((STATUS_W+SW+SPREAD_W+2*TOTAL_W+7)/8)*8;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_GDIV = 11'b00000000010,
    S_DD   = 11'b00000000100,
    S_Q    = 11'b00000001000,
    S_THR  = 11'b00000010000,
    S_MM   = 11'b00000100000,
    S_MD   = 11'b00001000000,
    S_QN   = 11'b00010000000,
    S_SD   = 11'b00100000000,
    S_OUT  = 11'b01000000000,
    S_HOLD = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [RATIO_W-1:0]   ratio_r;
  logic [MSPREAD_W-1:0] mspread_r;
  logic [MCOUNT_W-1:0]  mcount_r;

  // statistics
  logic [CW-1:0]       tc_r;
  logic [SW-1:0]       mean_r;
  logic [SPREAD_W-1:0] ssd_r;
  logic [TOTAL_W-1:0]  upd_r;

  // per-item working registers
  logic [SW-1:0]       sum_r;
  logic [GROUP_W-1:0]  n_r;
  logic                above_r;
  logic [UW-1:0]       q_r;
  logic                qovf_r, tovf_r;
  logic [STATUS_W-1:0] status_r;

  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;

  // shared unit
  alu_ctl_t      ctl;
  logic [UW-1:0] alu_a, alu_b, res;
  logic          done;

  rmv_alu #(.UW(UW), .DVW(CW)) u_alu (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .a_i(alu_a), .b_i(alu_b),
    .res_o(res), .done_o(done)
  );

  logic [SW-1:0]     g_sat;
  logic [CW:0]       c_ext;
  logic [CW-1:0]     c_val;
  logic [CMP_W-1:0]  thr;
  logic              ge, outlier;
  logic [SPREAD_W-1:0] inc;
  logic [SPREAD_W:0]   ss_ext;
  logic [UW-1:0]     scaled;
  logic              in_acc, out_free;
  logic [63:0]       tc64;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign scaled   = UW'(sum_r) << F;
  assign g_sat    = ((res >> SW) != '0) ? '1 : res[SW-1:0];
  assign c_ext    = {1'b0, tc_r} + (CW+1)'(n_r);
  assign c_val    = c_ext[CW-1:0];
  assign thr      = CMP_W'(res) << (F - RATIO_FRAC);
  assign ge       = qovf_r || (CMP_W'(q_r) >= thr);
  assign outlier  = (tc_r > CW'(mcount_r)) && (ssd_r > SPREAD_W'(mspread_r)) &&
                    above_r && ge;
  assign inc      = (tovf_r || ((res >> SPREAD_W) != '0)) ? '1 : res[SPREAD_W-1:0];
  assign ss_ext   = {1'b0, ssd_r} + {1'b0, inc};
  assign tc64     = 64'(tc_r);

  // sequencer: pick the next unit operation and its operands
  always_comb begin
    state_nxt = state_r;
    ctl       = '{start: 1'b0, op: OP_MUL, nbits: '0};
    alu_a     = '0;
    alu_b     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tdata[SW +: GROUP_W] == '0) begin
            state_nxt = S_OUT;
          end else begin
            ctl       = '{start: 1'b1, op: OP_DIV, nbits: CNT_W'(SW + F)};
            alu_a     = UW'(in_tdata[SW-1:0]) << F;
            alu_b     = UW'(in_tdata[SW +: GROUP_W]);
            state_nxt = S_GDIV;
          end
        end
      end
      S_GDIV: begin
        if (done) begin
          ctl       = '{start: 1'b1, op: OP_MUL, nbits: CNT_W'(SW)};
          alu_a     = (g_sat >= mean_r) ? UW'(g_sat - mean_r) : UW'(mean_r - g_sat);
          alu_b     = alu_a;
          state_nxt = S_DD;
        end
      end
      S_DD: begin
        if (done) begin
          ctl       = '{start: 1'b1, op: OP_MUL, nbits: CNT_W'(CW)};
          alu_a     = res;
          alu_b     = UW'(tc_r);
          state_nxt = S_Q;
        end
      end
      S_Q: begin
        if (done) begin
          ctl       = '{start: 1'b1, op: OP_MUL, nbits: CNT_W'(RATIO_W)};
          alu_a     = UW'(ssd_r);
          alu_b     = UW'(ratio_r);
          state_nxt = S_THR;
        end
      end
      S_THR: begin
        if (done) begin
          priority if (outlier) begin
            state_nxt = S_OUT;
          end else if (c_ext[CW]) begin
            state_nxt = S_OUT;
          end else begin
            ctl       = '{start: 1'b1, op: OP_MUL, nbits: CNT_W'(CW)};
            alu_a     = UW'(mean_r);
            alu_b     = UW'(tc_r);
            state_nxt = S_MM;
          end
        end
      end
      S_MM: begin
        if (done) begin
          ctl       = '{start: 1'b1, op: OP_DIV, nbits: CNT_W'(NUM_W)};
          alu_a     = res + scaled;
          alu_b     = UW'(c_val);
          state_nxt = S_MD;
        end
      end
      S_MD: begin
        if (done) begin
          ctl       = '{start: 1'b1, op: OP_MUL, nbits: CNT_W'(GROUP_W)};
          alu_a     = q_r;
          alu_b     = UW'(n_r);
          state_nxt = S_QN;
        end
      end
      S_QN: begin
        if (done) begin
          ctl       = '{start: 1'b1, op: OP_DIV, nbits: CNT_W'(UW - F)};
          alu_a     = res >> F;
          alu_b     = UW'(c_val);
          state_nxt = S_SD;
        end
      end
      S_SD: begin
        if (done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_HOLD: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ratio_r     <= RATIO_RST;
      mspread_r   <= MSPREAD_RST;
      mcount_r    <= MCOUNT_RST;
      tc_r        <= '0;
      mean_r      <= '0;
      ssd_r       <= '0;
      upd_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_RATIO:   ratio_r   <= cfg_data[RATIO_W-1:0];
          REG_MSPREAD: mspread_r <= cfg_data[MSPREAD_W-1:0];
          REG_MCOUNT:  mcount_r  <= cfg_data[MCOUNT_W-1:0];
          default: ;
        endcase
      end
      // load a new word, else drop the old one once taken
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_tready)              out_valid_r <= 1'b0;
      // commit the mean after its division, the spread and count after the last one
      if (state_r == S_MD && done) mean_r <= ((res >> SW) != '0) ? '1 : res[SW-1:0];
      if (state_r == S_SD && done) begin
        ssd_r <= ss_ext[SPREAD_W] ? '1 : ss_ext[SPREAD_W-1:0];
        tc_r  <= c_val;
        if (upd_r != '1) upd_r <= upd_r + TOTAL_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sum_r    <= in_tdata[SW-1:0];
      n_r      <= in_tdata[SW +: GROUP_W];
      status_r <= (in_tdata[SW +: GROUP_W] == '0) ? ST_ZERO : ST_OK;
    end
    if (state_r == S_GDIV && done) begin
      above_r <= (g_sat >= mean_r);
    end
    if (state_r == S_Q && done) begin
      q_r    <= res;
      qovf_r <= ((res >> WIDE_BITS) != '0);
    end
    if (state_r == S_THR && done) begin
      priority if (outlier) status_r <= ST_OUTLIER;
      else if (c_ext[CW])   status_r <= ST_OVF;
      else                  status_r <= ST_OK;
    end
    if (state_r == S_QN && done) tovf_r <= qovf_r || ((res >> WIDE_BITS) != '0);
    if (state_r == S_OUT && out_free) begin
      out_data_r <= OUT_W'({upd_r, tc64[TOTAL_W-1:0], ssd_r, mean_r, status_r});
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

endmodule

FILE: sv/rmv_alu.sv
// Shared bit-serial multiplier and restoring divider, one bit per cycle.
`timescale 1ns / 1ps
module rmv_alu #(
  parameter int UW  = 144,
  parameter int DVW = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rmv_pkg::alu_ctl_t   ctl,
  input  logic [UW-1:0]       a_i,
  input  logic [UW-1:0]       b_i,
  output logic [UW-1:0]       res_o,
  output logic                done_o
);
  import rmv_pkg::*;

  logic [UW-1:0]    acc_r, acc_nxt, a_r, a_nxt, b_r;
  logic [DVW-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  op_t              op_r;
  logic [DVW:0]     rem2;
  logic             qbit;

  always_comb begin
    rem2    = {rem_r, a_r[UW-1]};
    qbit    = (rem2 >= {1'b0, b_r[DVW-1:0]});
    rem_nxt = qbit ? DVW'(rem2 - {1'b0, b_r[DVW-1:0]}) : rem2[DVW-1:0];
    if (op_r == OP_DIV) begin
      a_nxt   = {a_r[UW-2:0], qbit};
      acc_nxt = acc_r;
    end else begin
      a_nxt   = {a_r[UW-2:0], 1'b0};
      acc_nxt = b_r[0] ? acc_r + a_r : acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (ctl.start) begin
      cnt_r  <= ctl.nbits;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (cnt_r != '0) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op_r  <= ctl.op;
      acc_r <= '0;
      rem_r <= '0;
      b_r   <= b_i;
      a_r   <= (ctl.op == OP_DIV) ? (a_i << (CNT_W'(UW) - ctl.nbits)) : a_i;
    end else if (cnt_r != '0) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      a_r   <= a_nxt;
      if (op_r == OP_MUL) b_r <= b_r >> 1;
    end
  end

  assign res_o  = (op_r == OP_DIV) ? a_r : acc_r;
  assign done_o = done_r;

endmodule

FILE: tb/sv/tb_running_mean_variance_outlier_unit.sv
// Testbench for the running mean / variance outlier unit with its own predictor.
`timescale 1ns / 1ps
module tb_running_mean_variance_outlier_unit;
  import rmv_pkg::*;

  localparam int SUMW   = 48;
  localparam int FRAC   = 16;
  localparam int IN_W   = 64;
  localparam int OUT_W  = 184;
  localparam int PHASES = 8;
  localparam int PER_PHASE = 230;

  typedef logic [255:0] wide_t;

  // One result word, unpacked.
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SUMW-1:0]     mean_value;
    logic [SPREAD_W-1:0] spread_sum;
    logic [TOTAL_W-1:0]  sample_total;
    logic [TOTAL_W-1:0]  update_total;
  } stats_t;

  // Scoreboard: tracks the statistics the block should hold and the results
  // still owed by the block, in order.
  class stats_scoreboard;
    logic [TOTAL_W-1:0]   count_acc;
    logic [SUMW-1:0]      mean_acc;
    logic [SPREAD_W-1:0]  spread_acc;
    logic [TOTAL_W-1:0]   updates_acc;
    logic [RATIO_W-1:0]   ratio;
    logic [MSPREAD_W-1:0] spread_floor;
    logic [MCOUNT_W-1:0]  count_floor;
    stats_t               owed[$];
    int                   errors;

    function new();
      count_acc = '0; mean_acc = '0; spread_acc = '0; updates_acc = '0;
      ratio = RATIO_RST; spread_floor = MSPREAD_RST; count_floor = MCOUNT_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_RATIO:   ratio = val[RATIO_W-1:0];
        REG_MSPREAD: spread_floor = val[MSPREAD_W-1:0];
        REG_MCOUNT:  count_floor = val[MCOUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply one weighted Welford step and queue the resulting report.
    function void note_input(logic [SUMW-1:0] sum, logic [GROUP_W-1:0] n);
      wide_t scaled, g, d, q, thr, num, term, inc, ss, c;
      wide_t mean_max, all64;
      stats_t r;
      logic above;
      mean_max = (wide_t'(1) << SUMW) - 1;
      all64 = (wide_t'(1) << 64) - 1;
      if (n == 0) begin
        r.status = ST_ZERO;
      end else begin
        scaled = wide_t'(sum) << FRAC;
        g = scaled / n;
        if (g > mean_max) g = mean_max;
        above = g >= mean_acc;
        d = above ? g - mean_acc : mean_acc - g;
        q = d * d * count_acc;
        thr = (wide_t'(spread_acc) * ratio) << (FRAC - RATIO_FRAC);
        if (count_acc > count_floor && spread_acc > spread_floor && above && q >= thr) begin
          r.status = ST_OUTLIER;
        end else if (wide_t'(n) > wide_t'(32'hFFFF_FFFF - count_acc)) begin
          r.status = ST_OVF;
        end else begin
          r.status = ST_OK;
          c = count_acc + n;
          num = wide_t'(mean_acc) * count_acc + scaled;
          num = num / c;
          mean_acc = (num > mean_max) ? mean_max[SUMW-1:0] : num[SUMW-1:0];
          term = q * n;
          if (term >= (wide_t'(1) << 128)) begin
            inc = all64;
          end else begin
            inc = (term >> FRAC) / c;
            if (inc > all64) inc = all64;
          end
          ss = wide_t'(spread_acc) + inc;
          spread_acc = (ss > all64) ? '1 : ss[63:0];
          count_acc = c[TOTAL_W-1:0];
          if (updates_acc != '1) updates_acc++;
        end
      end
      r.mean_value = mean_acc;
      r.spread_sum = spread_acc;
      r.sample_total = count_acc;
      r.update_total = updates_acc;
      owed.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    endtask

    task check(logic [OUT_W-1:0] word);
      stats_t e;
      if (owed.size() == 0) begin
        report("unexpected result word", word[63:0], 64'd0);
        return;
      end
      e = owed.pop_front();
      if (word[1:0] !== e.status) report("status", word[1:0], e.status);
      if (word[49:2] !== e.mean_value) report("mean_value", word[49:2], e.mean_value);
      if (word[113:50] !== e.spread_sum) report("spread_sum", word[113:50], e.spread_sum);
      if (word[145:114] !== e.sample_total)
        report("sample_total", word[145:114], e.sample_total);
      if (word[177:146] !== e.update_total)
        report("update_total", word[177:146], e.update_total);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic [IN_W-1:0]  in_tdata;
  logic in_tvalid, in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic out_tvalid, out_tready;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  stats_scoreboard sb;
  bit quiet;          // no idling on either side during this stretch
  bit hold_req;       // ask the receiver for one long hold-off
  logic [SUMW-1:0] level;   // typical per-sample value of the current phase

  running_mean_variance_outlier_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Hard limit on run time.
  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  // Offer one word; inputs are stable from negedge to the next posedge, so the
  // ready sampled there decides whether the coming edge accepts it.
  task send_word(logic [SUMW-1:0] sum, logic [GROUP_W-1:0] n);
    int gap;
    bit rdy;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {n, sum};
    in_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    sb.note_input(sum, n);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    bit rdy;
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Drop valid and hold until every owed result has come back.
  task drain;
    in_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Draw one input word: mostly groups scattered around the phase level, some
  // far above it, some noise over the full field ranges, a few empty groups and a few all-ones sums.
  task send_random;
    int pick;
    logic [GROUP_W-1:0] n;
    logic [63:0] s;
    pick = $urandom_range(0, 99);
    n = ($urandom_range(0, 9) == 0) ? GROUP_W'($urandom_range(1, 65535))
                                    : GROUP_W'($urandom_range(1, 16));
    s = 64'(level) * n;
    if (pick < 60) begin
      s = s + $urandom_range(0, 64) * n;
      if (s >= 64'(n) * 32) s = s - 32 * 64'(n);
    end else if (pick < 75) begin
      s = s * $urandom_range(2, 40) + $urandom_range(0, 1000);
    end else if (pick < 92) begin
      s = {$urandom, $urandom};
      n = GROUP_W'($urandom);
    end else if (pick < 96) begin
      n = '0;
      s = {$urandom, $urandom};
    end else begin
      s = '1;
      n = GROUP_W'($urandom_range(1, 3));
    end
    send_word(s[SUMW-1:0], n);
  endtask

  // Receiver: random stall before each word, one long hold-off on request.
  initial begin
    int stall;
    bit rdy;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        rdy = out_tvalid;
        @(posedge clk);
      end while (!rdy);
      sb.check(out_tdata);
    end
  end

  initial begin
    logic [RATIO_W-1:0]   ratio_set[PHASES]   = '{8'd100, 8'd0, 8'd255, 8'd16, 8'd1,
                                                   8'd100, 8'd40, 8'd200};
    logic [MSPREAD_W-1:0] spread_set[PHASES]  = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd1000,
                                                   32'd0, 32'd65536, 32'd300000, 32'd0};
    logic [MCOUNT_W-1:0]  count_set[PHASES]   = '{16'd2, 16'd0, 16'hFFFF, 16'd5, 16'd0,
                                                   16'd2, 16'd20, 16'd1};
    int wait_cnt;
    sb = new();
    quiet = 1'b0;
    hold_req = 1'b0;
    level = 48'd1000;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_RATIO;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first group, empty group, steady groups, spread, outliers,
    // saturating group mean, full-range fields.
    send_word(48'd0, 16'd0);
    send_word(48'd5000, 16'd5);
    send_word(48'd1000, 16'd1);
    send_word(48'd3000, 16'd2);
    send_word(48'd2000, 16'd4);
    send_word(48'd900, 16'd1);
    send_word(48'd1100, 16'd1);
    send_word(48'd500000, 16'd1);
    send_word(48'd10, 16'd1);
    send_word(48'hFFFF_FFFF_FFFF, 16'd1);
    send_word(48'hFFFF_FFFF_FFFF, 16'hFFFF);
    send_word(48'd0, 16'hFFFF);
    send_word(48'd0, 16'd1);
    send_word(48'h8000_0000_0000, 16'h8000);
    send_word(48'h5555_5555_5555, 16'h5555);
    send_word(48'hAAAA_AAAA_AAAA, 16'hAAAA);
    send_word(48'd123456, 16'd0);
    send_word(48'd1, 16'd1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      // Registers change only with the block idle.
      write_reg(REG_RATIO, 32'(ratio_set[p]));
      write_reg(REG_MSPREAD, spread_set[p]);
      write_reg(REG_MCOUNT, 32'(count_set[p]));
      quiet = (p == 3);
      level = (p % 2) ? SUMW'($urandom_range(1, 1 << 20)) : SUMW'($urandom_range(1, 5000));
      for (int k = 0; k < PER_PHASE; k++) begin
        if (p == 2 && k == 50) hold_req = 1'b1;  // receiver backs up the block
        send_random();
      end
      drain();
    end

    wait_cnt = 0;
    while (sb.owed.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (1000) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
